// ===== hdl/sentence_boundary_detector_assert.svh =====
// assertion macros for the sentence boundary detector
`ifndef SENTENCE_BOUNDARY_DETECTOR_ASSERT_SVH
`define SENTENCE_BOUNDARY_DETECTOR_ASSERT_SVH

// same-cycle implication
`define SBD_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SBD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbd_pkg.sv =====
// shared types, character codes and abbreviation table for the sentence boundary detector
`default_nettype none

package sbd_pkg;

  // scan phases
  localparam logic [1:0] PH_PLAIN = 2'd0;
  localparam logic [1:0] PH_TERM  = 2'd1;
  localparam logic [1:0] PH_CLOSE = 2'd2;
  localparam logic [1:0] PH_SPACE = 2'd3;

  // code units of interest
  localparam logic [15:0] CU_PERIOD   = 16'h002E;
  localparam logic [15:0] CU_BANG     = 16'h0021;
  localparam logic [15:0] CU_QUEST    = 16'h003F;
  localparam logic [15:0] CU_ELLIPSIS = 16'h2026;
  localparam logic [15:0] CU_DQUOTE   = 16'h0022;
  localparam logic [15:0] CU_SQUOTE   = 16'h0027;
  localparam logic [15:0] CU_LPAREN   = 16'h0028;
  localparam logic [15:0] CU_RPAREN   = 16'h0029;
  localparam logic [15:0] CU_LBRACK   = 16'h005B;
  localparam logic [15:0] CU_RBRACK   = 16'h005D;
  localparam logic [15:0] CU_LBRACE   = 16'h007B;
  localparam logic [15:0] CU_RBRACE   = 16'h007D;
  localparam logic [15:0] CU_RDQUOTE  = 16'h201D;
  localparam logic [15:0] CU_RSQUOTE  = 16'h2019;
  localparam logic [15:0] CU_RGUIL    = 16'h00BB;
  localparam logic [15:0] CU_LDQUOTE  = 16'h201C;
  localparam logic [15:0] CU_LSQUOTE  = 16'h2018;
  localparam logic [15:0] CU_LGUIL    = 16'h00AB;
  localparam logic [15:0] CU_EMDASH   = 16'h2014;
  localparam logic [15:0] CU_ENDASH   = 16'h2013;
  localparam logic [15:0] CU_ASCII_END = 16'h0080;
  localparam logic [15:0] CU_CASE_BIT  = 16'h0020;
  localparam logic [15:0] CU_LOWER_A   = 16'h0061;
  localparam logic [15:0] CU_LOWER_Z   = 16'h007A;

  // abbreviation table, right-justified ascii: byte 0 holds the last letter
  localparam int ABBR_WORD_MAX = 6;
  localparam int ABBR_COUNT    = 40;
  typedef logic [8*ABBR_WORD_MAX-1:0] abbr_word_t;

  localparam abbr_word_t ABBR_TABLE [ABBR_COUNT] = '{
    "mr", "mrs", "ms", "dr", "prof", "st", "jr", "sr", "vs", "etc",
    "fig", "figs", "vol", "vols", "ch", "chap", "rev", "hon", "capt", "lt",
    "col", "gen", "sgt", "mt", "ave", "inc", "ltd", "co", "corp", "cf",
    "al", "viz", "ibid", "op", "messrs", "esq", "dept", "univ", "approx", "pp"
  };

  function automatic int abbr_len(abbr_word_t w);
    int n;
    n = 0;
    for (int i = 0; i < ABBR_WORD_MAX; i++) begin
      if (w[8*i +: 8] != 8'h00) n = i + 1;
    end
    return n;
  endfunction

  function automatic logic is_term(logic [15:0] c);
    return (c == CU_PERIOD) || (c == CU_BANG) || (c == CU_QUEST) || (c == CU_ELLIPSIS);
  endfunction

  function automatic logic is_closer(logic [15:0] c);
    return (c == CU_DQUOTE) || (c == CU_SQUOTE) || (c == CU_RPAREN) ||
           (c == CU_RBRACK) || (c == CU_RBRACE) || (c == CU_RDQUOTE) ||
           (c == CU_RSQUOTE) || (c == CU_RGUIL);
  endfunction

  function automatic logic can_start(logic [15:0] c, logic upper, logic digit);
    return upper || digit ||
           (c == CU_DQUOTE) || (c == CU_SQUOTE) || (c == CU_LPAREN) ||
           (c == CU_LBRACK) || (c == CU_LBRACE) || (c == CU_LDQUOTE) ||
           (c == CU_LSQUOTE) || (c == CU_LGUIL) || (c == CU_EMDASH) ||
           (c == CU_ENDASH);
  endfunction

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef struct packed {
    logic [15:0] sentence_end;
    logic        final_boundary;
  } sbd_result_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [15:0] pos;
  } sbd_scan_stat_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
  } sbd_q_stat_t;

endpackage

`default_nettype wire

// ===== hdl/sbd_abbrev.sv =====
// parallel match of the recent letter window against the abbreviation table
`default_nettype none

module sbd_abbrev
  import sbd_pkg::*;
#(
  parameter int ABBREV_MAX_LEN = 6,
  localparam int RUN_W = $clog2(ABBREV_MAX_LEN + 2)
) (
  input  wire logic [RUN_W-1:0]                run_len,
  input  wire logic                            matchable,
  input  wire logic [ABBREV_MAX_LEN-1:0][4:0]  recent,
  output logic                                 hit
);

  logic [ABBR_WORD_MAX-1:0][4:0] win;
  logic [ABBR_COUNT-1:0]         word_hit;

  // window padded to the longest table word, letters beyond the tracked depth read zero
  for (genvar i = 0; i < ABBR_WORD_MAX; i++) begin : g_win
    if (i < ABBREV_MAX_LEN) begin : g_live
      assign win[i] = recent[i];
    end else begin : g_pad
      assign win[i] = 5'd0;
    end
  end

  for (genvar e = 0; e < ABBR_COUNT; e++) begin : g_word
    localparam int WL = abbr_len(ABBR_TABLE[e]);
    if (WL <= ABBREV_MAX_LEN) begin : g_fit
      logic [ABBR_WORD_MAX-1:0] letter_ok;
      for (genvar t = 0; t < ABBR_WORD_MAX; t++) begin : g_letter
        if (t < WL) begin : g_cmp
          assign letter_ok[t] = (win[t] == ABBR_TABLE[e][8*t +: 5]);
        end else begin : g_free
          assign letter_ok[t] = 1'b1;
        end
      end
      assign word_hit[e] = (run_len == RUN_W'(WL)) && (&letter_ok);
    end else begin : g_long
      assign word_hit[e] = 1'b0;
    end
  end

  // a one-letter token is an initial
  assign hit = (run_len == RUN_W'(1)) || (matchable && (|word_hit));

endmodule

`default_nettype wire

// ===== hdl/sbd_scan.sv =====
// per-code-unit scanner: phase, position, letter tracking and result generation
`default_nettype none

module sbd_scan
  import sbd_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_LEN   = 65535,
  parameter int              ABBREV_MAX_LEN = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [15:0] code_unit,
  input  wire logic        is_letter,
  input  wire logic        is_upper,
  input  wire logic        is_digit,
  input  wire logic        is_space,
  input  wire logic        end_of_text,
  output sbd_result_t      res0,
  output sbd_result_t      res1,
  output logic [1:0]       res_cnt,
  output sbd_scan_stat_t   stat
);

  localparam int RUN_W = $clog2(ABBREV_MAX_LEN + 2);
  localparam logic [15:0] OFF_LIMIT =
    (MAX_TEXT_LEN < 64'd65535) ? MAX_TEXT_LEN[15:0] : 16'hFFFF;
  localparam logic [RUN_W-1:0] RUN_SAT = RUN_W'(ABBREV_MAX_LEN + 1);

  logic [1:0]                           phase_r, phase_nxt;
  logic [15:0]                          pos_r, pos_nxt;
  logic [RUN_W-1:0]                     run_r, run_nxt;
  logic                                 match_r, match_nxt;
  logic                                 supp_r, supp_nxt;
  logic [15:0]                          cut_r, cut_nxt;
  logic [ABBREV_MAX_LEN-1:0][4:0]       recent_r, recent_nxt;

  logic        term;
  logic        closer;
  logic        go_plain;
  logic        emit_mid;
  logic        emit_eot_cut;
  logic        abbr_hit;
  logic        ascii_letter;
  logic [15:0] folded;
  logic [4:0]  letter_code;
  logic [15:0] pos_inc;
  logic [1:0]  phase_scan;
  logic        supp_scan;
  logic [15:0] cut_scan;

  sbd_abbrev #(
    .ABBREV_MAX_LEN(ABBREV_MAX_LEN)
  ) u_abbrev (
    .run_len   (run_r),
    .matchable (match_r),
    .recent    (recent_r),
    .hit       (abbr_hit)
  );

  assign term         = is_term(code_unit);
  assign closer       = is_closer(code_unit);
  assign folded       = code_unit | CU_CASE_BIT;
  assign ascii_letter = (code_unit < CU_ASCII_END) && (folded >= CU_LOWER_A) &&
                        (folded <= CU_LOWER_Z);
  assign letter_code  = ascii_letter ? folded[4:0] : 5'd0;
  assign pos_inc      = (pos_r < OFF_LIMIT) ? pos_r + 16'd1 : pos_r;

  always_comb begin
    phase_scan = phase_r;
    supp_scan  = supp_r;
    cut_scan   = cut_r;
    go_plain   = 1'b0;
    emit_mid   = 1'b0;
    unique case (phase_r)
      PH_TERM: begin
        if (term) supp_scan = 1'b0;
        else if (closer) phase_scan = PH_CLOSE;
        else if (is_space) begin
          cut_scan   = pos_r;
          phase_scan = PH_SPACE;
        end else go_plain = 1'b1;
      end
      PH_CLOSE: begin
        if (closer) phase_scan = PH_CLOSE;
        else if (is_space) begin
          cut_scan   = pos_r;
          phase_scan = PH_SPACE;
        end else go_plain = 1'b1;
      end
      PH_SPACE: begin
        if (!is_space) begin
          emit_mid = !supp_r && can_start(code_unit, is_upper, is_digit);
          go_plain = 1'b1;
        end
      end
      PH_PLAIN: begin
        go_plain = 1'b1;
      end
    endcase
    // the rejecting character is scanned again as plain text
    if (go_plain) begin
      if (term) begin
        phase_scan = PH_TERM;
        supp_scan  = (code_unit == CU_PERIOD) && abbr_hit;
      end else begin
        phase_scan = PH_PLAIN;
        supp_scan  = 1'b0;
      end
    end
  end

  // a cut that lands on the paragraph end is covered by the final beat
  assign emit_eot_cut = (phase_scan == PH_SPACE) && !supp_scan && (cut_scan != pos_inc);

  always_comb begin
    res0.sentence_end   = cut_scan;
    res0.final_boundary = 1'b0;
    res1.sentence_end   = pos_inc;
    res1.final_boundary = 1'b1;
    res_cnt             = {1'b0, emit_mid};
    if (end_of_text) begin
      if (emit_mid || emit_eot_cut) begin
        res_cnt = 2'd2;
      end else begin
        res0    = res1;
        res_cnt = 2'd1;
      end
    end
  end

  always_comb begin
    if (end_of_text) begin
      phase_nxt  = PH_PLAIN;
      pos_nxt    = 16'd0;
      run_nxt    = '0;
      match_nxt  = 1'b1;
      supp_nxt   = 1'b0;
      cut_nxt    = 16'd0;
      recent_nxt = '0;
    end else begin
      phase_nxt = phase_scan;
      pos_nxt   = pos_inc;
      supp_nxt  = supp_scan;
      cut_nxt   = cut_scan;
      if (is_letter) begin
        run_nxt    = (run_r < RUN_SAT) ? run_r + RUN_W'(1) : run_r;
        match_nxt  = match_r && ascii_letter;
        recent_nxt = {recent_r[ABBREV_MAX_LEN-2:0], letter_code};
      end else begin
        run_nxt    = '0;
        match_nxt  = 1'b1;
        recent_nxt = recent_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      pos_r   <= 16'd0;
      run_r   <= '0;
      match_r <= 1'b1;
      supp_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      run_r   <= run_nxt;
      match_r <= match_nxt;
      supp_r  <= supp_nxt;
    end
  end

  // payload: only read after being written within the current token or candidate
  always_ff @(posedge clk) begin
    if (accept) begin
      cut_r    <= cut_nxt;
      recent_r <= recent_nxt;
    end
  end

  assign stat.phase = phase_r;
  assign stat.pos   = pos_r;

endmodule

`default_nettype wire

// ===== hdl/sbd_outq.sv =====
// four-entry result queue, up to two writes and one read per cycle
`default_nettype none

module sbd_outq
  import sbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  push_cnt,
  input  wire sbd_result_t d0,
  input  wire sbd_result_t d1,
  input  wire logic        pop,
  output sbd_result_t      head,
  output sbd_q_stat_t      stat
);

  sbd_result_t        q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, wr_nxt;
  logic [Q_PTR_W-1:0] rd_r, rd_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0] wr_second;

  assign wr_second = wr_r + Q_PTR_W'(1);
  assign wr_nxt    = wr_r + push_cnt[Q_PTR_W-1:0];
  assign rd_nxt    = rd_r + Q_PTR_W'(pop);
  assign cnt_nxt   = cnt_r + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      if ((push_cnt != 2'd0) && (wr_r == Q_PTR_W'(i))) q_r[i] <= d0;
      if ((push_cnt == 2'd2) && (wr_second == Q_PTR_W'(i))) q_r[i] <= d1;
    end
  end

  assign head       = q_r[rd_r];
  assign stat.count = cnt_r;

endmodule

`default_nettype wire

// ===== hdl/sentence_boundary_detector.sv =====
// Sentence boundary detector: takes one UTF-16 code unit per cycle with its class flags
// and returns the exclusive end offset of each sentence, the paragraph length last with
// final_boundary set. Each code unit is decided in the cycle it is accepted, by the
// scanner's logic between its state registers and a four-entry result queue; an item
// can enter every cycle. A code unit makes at most two results (only on end_of_text),
// and in_stall rises while fewer than two queue slots are free, so the input runs at
// one code unit per cycle whenever results drain at one beat per cycle. The first
// result of a code unit can be taken the cycle after it was accepted. Offsets saturate
// at the smaller of MAX_TEXT_LEN and 65535.
`default_nettype none

`include "sentence_boundary_detector_assert.svh"

module sentence_boundary_detector
  import sbd_pkg::*;
#(
  parameter longint unsigned MAX_TEXT_LEN   = 65535,
  parameter int              ABBREV_MAX_LEN = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_code_unit,
  input  wire logic        in_is_letter,
  input  wire logic        in_is_upper,
  input  wire logic        in_is_digit,
  input  wire logic        in_is_space,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_sentence_end,
  output logic             out_final_boundary
);

  localparam logic [15:0] OFF_LIMIT =
    (MAX_TEXT_LEN < 64'd65535) ? MAX_TEXT_LEN[15:0] : 16'hFFFF;

  logic           in_acc;
  logic           out_acc;
  sbd_result_t    res0;
  sbd_result_t    res1;
  logic [1:0]     res_cnt;
  logic [1:0]     push_cnt;
  sbd_result_t    head;
  sbd_scan_stat_t scan_stat;
  sbd_q_stat_t    q_stat;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign push_cnt = in_acc ? res_cnt : 2'd0;

  sbd_scan #(
    .MAX_TEXT_LEN   (MAX_TEXT_LEN),
    .ABBREV_MAX_LEN (ABBREV_MAX_LEN)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .code_unit   (in_code_unit),
    .is_letter   (in_is_letter),
    .is_upper    (in_is_upper),
    .is_digit    (in_is_digit),
    .is_space    (in_is_space),
    .end_of_text (in_end_of_text),
    .res0        (res0),
    .res1        (res1),
    .res_cnt     (res_cnt),
    .stat        (scan_stat)
  );

  sbd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (push_cnt),
    .d0       (res0),
    .d1       (res1),
    .pop      (out_acc),
    .head     (head),
    .stat     (q_stat)
  );

  // room for a worst-case pair of results
  assign in_stall           = (q_stat.count > Q_CNT_W'(Q_DEPTH - 2));
  assign out_valid          = (q_stat.count != '0);
  assign out_sentence_end   = head.sentence_end;
  assign out_final_boundary = head.final_boundary;

  `SBD_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, q_stat.count <= Q_CNT_W'(Q_DEPTH), "result queue overflow")
  `SBD_ASSERT_NEXT(a_eot_rearm, clk, rst_n, in_acc && in_end_of_text, (scan_stat.pos == 16'd0) && (scan_stat.phase == PH_PLAIN), "scanner not rearmed after paragraph end")
  `SBD_ASSERT_NEXT(a_pos_step, clk, rst_n, in_acc && !in_end_of_text && (scan_stat.pos < OFF_LIMIT), scan_stat.pos == $past(scan_stat.pos) + 16'd1, "position did not advance")

endmodule

`default_nettype wire
